// ===== rtl/core/hmac_sha256_engine_macros.svh =====
// Assertion macros for the HMAC-SHA256 engine.
// Included by hs_core and hmac_sha256_engine; no other dependencies.
`ifndef HMAC_SHA256_ENGINE_MACROS_SVH
`define HMAC_SHA256_ENGINE_MACROS_SVH

// same-cycle implication
`define HS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hs_pkg.sv =====
// Shared types, constants and functions for the HMAC-SHA256 engine.
// No dependencies; imported by hs_core, hs_buf and hmac_sha256_engine.
package hs_pkg;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;

    typedef struct packed {
        logic        blk_we;
        logic        key_we;
        logic        key_clr_hi;
        logic        key_clr_all;
        logic [3:0]  addr;
        logic [31:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic load;
        logic start;
        logic use_iv;
    } core_ctl_t;

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'h000, x[31:10]};
    endfunction

endpackage

// ===== rtl/core/hs_buf.sv =====
// Key block and message block memories, 16 x 32 each, with registered read.
// Depends on hs_pkg; key entries read as zero until written.
module hs_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  hs_pkg::mem_req_t req,
    output logic [31:0]      blk_rdata,
    output logic [31:0]      key_rdata
);
    import hs_pkg::*;

    logic [31:0] blk_mem [16];
    logic [31:0] key_mem [16];
    logic [31:0] blk_rd_reg;
    logic [31:0] key_rd_reg;
    logic [15:0] key_vld_reg;
    logic [15:0] key_vld_next;
    logic        rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.blk_we)
        begin
            blk_mem[req.addr] <= req.wdata;
        end
        if (req.key_we)
        begin
            key_mem[req.addr] <= req.wdata;
        end
        blk_rd_reg <= blk_mem[req.addr];
        key_rd_reg <= key_mem[req.addr];
    end

    always_comb
    begin
        key_vld_next = key_vld_reg;
        if (req.key_we)
        begin
            key_vld_next[req.addr] = 1'b1;
        end
        if (req.key_clr_hi)
        begin
            key_vld_next[15:8] = 8'h00;
        end
        if (req.key_clr_all)
        begin
            key_vld_next = 16'h0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_vld_reg <= 16'h0000;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            key_vld_reg <= key_vld_next;
            rd_vld_reg  <= key_vld_reg[req.addr];
        end
    end

    assign blk_rdata = blk_rd_reg;
    assign key_rdata = rd_vld_reg ? key_rd_reg : 32'h0;

endmodule

// ===== rtl/core/hs_core.sv =====
// SHA-256 compression unit: 16-word schedule window, one round per cycle.
// Depends on hs_pkg; holds the chaining value and exposes it by word index.
`include "hmac_sha256_engine_macros.svh"
module hs_core (
    input  logic              clk,
    input  logic              rst_n,
    input  hs_pkg::core_ctl_t ctl,
    input  logic [31:0]       load_word,
    input  logic [2:0]        h_idx,
    output logic [31:0]       h_word,
    output logic              done
);
    import hs_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [5:0]  rnd_reg;
    logic        busy_reg;
    logic        fin_reg;
    logic        done_reg;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb
    begin
        w_new = sml_sig1(w_reg[14]) + w_reg[9] + sml_sig0(w_reg[1]) + w_reg[0];
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + big_sig1(v_reg[4]) + ch + SHA_K[rnd_reg] + w_reg[0];
        t2    = big_sig0(v_reg[0]) + maj;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= load_word;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
        if (ctl.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= ctl.use_iv ? SHA_IV[i] : h_reg[i];
                h_reg[i] <= ctl.use_iv ? SHA_IV[i] : h_reg[i];
            end
        end
        else if (busy_reg)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else if (fin_reg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg  <= 6'd0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    assign h_word = h_reg[h_idx];
    assign done   = done_reg;

    `HS_ASSERT_IMP(a_start_idle, clk, rst_n, ctl.start, !busy_reg && !fin_reg, "start while busy")
    `HS_ASSERT_IMP(a_load_idle, clk, rst_n, ctl.load, !busy_reg, "load during rounds")
    `HS_ASSERT_NXT(a_last_round, clk, rst_n, busy_reg && rnd_reg == 6'd63, fin_reg, "no final add")
    `HS_ASSERT_NXT(a_fin_done, clk, rst_n, fin_reg, done_reg && !busy_reg, "no done after add")

endmodule

// ===== rtl/core/hmac_sha256_engine.sv =====
// HMAC-SHA256 engine top level: input sequencer, padding and output stage.
// Depends on hs_pkg, hs_buf, hs_core and hmac_sha256_engine_macros.svh.
//
// Usage: key items (func = 0) are sent first, closed by an item with last = 1;
// message items (func = 1) follow, again closed by last = 1. byte_valid = 0 with
// last = 1 closes an empty part. Items of the wrong part are taken and dropped.
// A full 64-byte block starts a compression: its words are loaded into the
// schedule window, then the single round unit runs the rounds and adds the
// result into the chaining value. Closing a part pads byte by byte before
// its last compression. After the message closes, the MAC needs 3 or 4
// compressions plus padding, then leaves as eight 32-bit
// words, most significant first, last_word set on the eighth. in_ready is low
// while the engine works or while results are pending; a stalled receiver
// holds the current word in the output register. After the eighth word is
// taken, the engine clears its key and counters and waits for a new key.
// Reset clears the key block and all control state at once; no clearing pass.
`include "hmac_sha256_engine_macros.svh"
module hmac_sha256_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic        last_word
);
    import hs_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_RUN   = 4'd2;
    localparam logic [3:0] S_PAD   = 4'd3;
    localparam logic [3:0] S_LEN   = 4'd4;
    localparam logic [3:0] S_KEYWR = 4'd5;
    localparam logic [3:0] S_INWR  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    localparam logic [1:0] PH_KEY  = 2'd0;
    localparam logic [1:0] PH_LKEY = 2'd1;
    localparam logic [1:0] PH_MSG  = 2'd2;

    localparam logic [1:0] ST_LKEY  = 2'd0;
    localparam logic [1:0] ST_INNER = 2'd1;
    localparam logic [1:0] ST_OUTER = 2'd2;

    localparam logic [1:0] NX_IDLE  = 2'd0;
    localparam logic [1:0] NX_PAD   = 2'd1;
    localparam logic [1:0] NX_FINAL = 2'd2;

    localparam logic SRC_BLK = 1'b0;
    localparam logic SRC_KEY = 1'b1;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  stage_reg, stage_next;
    logic [1:0]  nx_reg, nx_next;
    logic        src_reg, src_next;
    logic [7:0]  pad_reg, pad_next;
    logic        iv_reg, iv_next;
    logic        first_reg, first_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [6:0]  fill_reg, fill_next;
    logic [63:0] bc_reg, bc_next;
    logic [63:0] klen_reg, klen_next;
    logic [31:0] acc_reg, acc_next;
    logic        ov_reg, ov_next;
    logic [31:0] dw_reg, dw_next;
    logic        lw_reg, lw_next;

    mem_req_t    req;
    core_ctl_t   cctl;
    logic [31:0] cword;
    logic [31:0] blk_rdata;
    logic [31:0] key_rdata;
    logic [31:0] h_word;
    logic        core_done;
    logic [7:0]  pb;
    logic [31:0] acc_p;
    logic [31:0] acc_k;
    logic        key_item;
    logic        msg_item;
    logic        go36;

    function automatic logic [31:0] place(input logic [31:0] acc, input logic [1:0] idx,
                                          input logic [7:0] b);
        logic [31:0] r;
        case (idx)
            2'd0:    r = {b, 24'h0};
            2'd1:    r = {acc[31:24], b, 16'h0};
            2'd2:    r = {acc[31:16], b, 8'h0};
            default: r = {acc[31:8], b};
        endcase
        return r;
    endfunction

    hs_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .blk_rdata (blk_rdata),
        .key_rdata (key_rdata)
    );

    hs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cctl),
        .load_word (cword),
        .h_idx     (cnt_reg[2:0]),
        .h_word    (h_word),
        .done      (core_done)
    );

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        stage_next = stage_reg;
        nx_next    = nx_reg;
        src_next   = src_reg;
        pad_next   = pad_reg;
        iv_next    = iv_reg;
        first_next = first_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        bc_next    = bc_reg;
        klen_next  = klen_reg;
        acc_next   = acc_reg;
        ov_next    = ov_reg;
        dw_next    = dw_reg;
        lw_next    = lw_reg;
        req        = '0;
        cctl       = '0;
        cword      = 32'h0;
        go36       = 1'b0;

        pb       = (state_reg == S_PAD) ? (first_reg ? 8'h80 : 8'h00) : data_byte;
        acc_p    = place(acc_reg, fill_reg[1:0], pb);
        acc_k    = place(acc_reg, klen_reg[1:0], data_byte);
        key_item = (phase_reg != PH_MSG) && !func;
        msg_item = (phase_reg == PH_MSG) && func;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (key_item && byte_valid)
                    begin
                        klen_next = klen_reg + 64'd1;
                    end
                    if ((key_item && phase_reg == PH_LKEY) || msg_item)
                    begin
                        if (byte_valid)
                        begin
                            acc_next = acc_p;
                            bc_next  = bc_reg + 64'd8;
                            if (fill_reg[1:0] == 2'd3)
                            begin
                                req.blk_we = 1'b1;
                                req.addr   = fill_reg[5:2];
                                req.wdata  = acc_p;
                            end
                            if (fill_reg == 7'd63)
                            begin
                                fill_next  = 7'd0;
                                state_next = S_LOAD;
                                cnt_next   = 5'd0;
                                src_next   = SRC_BLK;
                                iv_next    = 1'b0;
                                nx_next    = last ? NX_PAD : NX_IDLE;
                                first_next = 1'b1;
                            end
                            else
                            begin
                                fill_next = fill_reg + 7'd1;
                                if (last)
                                begin
                                    state_next = S_PAD;
                                    first_next = 1'b1;
                                end
                            end
                        end
                        else if (last)
                        begin
                            state_next = S_PAD;
                            first_next = 1'b1;
                        end
                    end
                    else if (key_item)
                    begin
                        if (byte_valid && klen_reg[63:6] == 58'd0)
                        begin
                            acc_next = acc_k;
                            if (klen_reg[1:0] == 2'd3 || last)
                            begin
                                req.key_we = 1'b1;
                                req.addr   = klen_reg[5:2];
                                req.wdata  = acc_k;
                            end
                            go36 = last;
                        end
                        else if (byte_valid)
                        begin
                            phase_next = PH_LKEY;
                            stage_next = ST_LKEY;
                            acc_next   = {data_byte, 24'h0};
                            fill_next  = 7'd1;
                            bc_next    = 64'd520;
                            state_next = S_LOAD;
                            cnt_next   = 5'd0;
                            src_next   = SRC_KEY;
                            pad_next   = 8'h00;
                            iv_next    = 1'b1;
                            nx_next    = last ? NX_PAD : NX_IDLE;
                            first_next = 1'b1;
                        end
                        else
                        begin
                            // partial key word still in acc
                            if (last && klen_reg[63:6] == 58'd0 && klen_reg[1:0] != 2'd0)
                            begin
                                req.key_we = 1'b1;
                                req.addr   = klen_reg[5:2];
                                req.wdata  = acc_reg;
                            end
                            go36 = last;
                        end
                    end
                end
            end
            S_LOAD:
            begin
                if (cnt_reg != 5'd16)
                begin
                    req.addr = cnt_reg[3:0];
                end
                if (cnt_reg != 5'd0)
                begin
                    cctl.load = 1'b1;
                    cword     = (src_reg == SRC_BLK) ? blk_rdata : (key_rdata ^ {4{pad_reg}});
                end
                if (cnt_reg == 5'd16)
                begin
                    cctl.start  = 1'b1;
                    cctl.use_iv = iv_reg;
                    state_next  = S_RUN;
                    cnt_next    = 5'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_RUN:
            begin
                if (core_done)
                begin
                    cnt_next = 5'd0;
                    case (nx_reg)
                        NX_IDLE: state_next = S_IDLE;
                        NX_PAD:  state_next = S_PAD;
                        default:
                        begin
                            case (stage_reg)
                                ST_LKEY:  state_next = S_KEYWR;
                                ST_INNER: state_next = S_INWR;
                                default:  state_next = S_OUT;
                            endcase
                        end
                    endcase
                end
            end
            S_PAD:
            begin
                if (!first_reg && fill_reg == 7'd56)
                begin
                    state_next = S_LEN;
                    cnt_next   = 5'd0;
                end
                else
                begin
                    acc_next   = acc_p;
                    first_next = 1'b0;
                    if (fill_reg[1:0] == 2'd3)
                    begin
                        req.blk_we = 1'b1;
                        req.addr   = fill_reg[5:2];
                        req.wdata  = acc_p;
                    end
                    if (fill_reg == 7'd63)
                    begin
                        fill_next  = 7'd0;
                        state_next = S_LOAD;
                        cnt_next   = 5'd0;
                        src_next   = SRC_BLK;
                        iv_next    = 1'b0;
                        nx_next    = NX_PAD;
                    end
                    else
                    begin
                        fill_next = fill_reg + 7'd1;
                    end
                end
            end
            S_LEN:
            begin
                req.blk_we = 1'b1;
                if (cnt_reg == 5'd0)
                begin
                    req.addr  = 4'd14;
                    req.wdata = bc_reg[63:32];
                    cnt_next  = 5'd1;
                end
                else
                begin
                    req.addr   = 4'd15;
                    req.wdata  = bc_reg[31:0];
                    fill_next  = 7'd0;
                    state_next = S_LOAD;
                    cnt_next   = 5'd0;
                    src_next   = SRC_BLK;
                    iv_next    = 1'b0;
                    nx_next    = NX_FINAL;
                end
            end
            S_KEYWR:
            begin
                req.key_we = 1'b1;
                req.addr   = cnt_reg[3:0];
                req.wdata  = h_word;
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == 5'd7)
                begin
                    req.key_clr_hi = 1'b1;
                    go36           = 1'b1;
                end
            end
            S_INWR:
            begin
                req.blk_we = 1'b1;
                req.addr   = cnt_reg[3:0];
                req.wdata  = h_word;
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == 5'd7)
                begin
                    stage_next = ST_OUTER;
                    fill_next  = 7'd32;
                    bc_next    = 64'd768;
                    state_next = S_LOAD;
                    cnt_next   = 5'd0;
                    src_next   = SRC_KEY;
                    pad_next   = OPAD;
                    iv_next    = 1'b1;
                    nx_next    = NX_PAD;
                    first_next = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    if (cnt_reg != 5'd8)
                    begin
                        ov_next  = 1'b1;
                        dw_next  = h_word;
                        lw_next  = (cnt_reg == 5'd7);
                        cnt_next = cnt_reg + 5'd1;
                    end
                    else
                    begin
                        ov_next         = 1'b0;
                        state_next      = S_IDLE;
                        phase_next      = PH_KEY;
                        klen_next       = 64'd0;
                        fill_next       = 7'd0;
                        bc_next         = 64'd0;
                        req.key_clr_all = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (go36)
        begin
            state_next = S_LOAD;
            cnt_next   = 5'd0;
            src_next   = SRC_KEY;
            pad_next   = IPAD;
            iv_next    = 1'b1;
            nx_next    = NX_IDLE;
            phase_next = PH_MSG;
            stage_next = ST_INNER;
            fill_next  = 7'd0;
            bc_next    = 64'd512;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_KEY;
            stage_reg <= ST_INNER;
            nx_reg    <= NX_IDLE;
            src_reg   <= SRC_BLK;
            pad_reg   <= 8'h00;
            iv_reg    <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= 5'd0;
            fill_reg  <= 7'd0;
            bc_reg    <= 64'd0;
            klen_reg  <= 64'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            stage_reg <= stage_next;
            nx_reg    <= nx_next;
            src_reg   <= src_next;
            pad_reg   <= pad_next;
            iv_reg    <= iv_next;
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
            fill_reg  <= fill_next;
            bc_reg    <= bc_next;
            klen_reg  <= klen_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        dw_reg  <= dw_next;
        lw_reg  <= lw_next;
    end

    assign out_valid   = ov_reg;
    assign digest_word = dw_reg;
    assign last_word   = lw_reg;

    `HS_ASSERT_IMP(a_ready_no_out, clk, rst_n, in_ready, !out_valid, "input open with MAC pending")
    `HS_ASSERT_IMP(a_fill_range, clk, rst_n, state_reg == S_IDLE, fill_reg < 7'd64, "fill overflow")
    `HS_ASSERT_IMP(a_last_cnt, clk, rst_n, out_valid && last_word, cnt_reg == 5'd8, "last word early")
    `HS_ASSERT_NXT(a_pad_first, clk, rst_n, first_reg && state_reg == S_PAD, !first_reg, "pad lost")

endmodule

// ===== tb/tb_hmac_sha256_engine.sv =====
// Self-checking testbench for hmac_sha256_engine: streams key and message bytes,
// predicts each MAC with its own HMAC-SHA256 model and checks every digest word.
// Depends on the engine RTL only.
module tb_hmac_sha256_engine;

    localparam logic FUNC_KEY = 1'b0;
    localparam logic FUNC_MSG = 1'b1;
    localparam logic [7:0] PAD_IN = 8'h36;
    localparam logic [7:0] PAD_OUT = 8'h5c;

    typedef enum logic [1:0] {
        WAIT_KEY  = 2'd0,
        LONG_KEY  = 2'd1,
        WAIT_MSG  = 2'd2
    } mac_phase_e;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
        logic       hold;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic        last_word;
    } mac_word_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] START_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic        last_word;

    hmac_sha256_engine uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .data_byte(data_byte), .byte_valid(byte_valid), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .last_word(last_word)
    );

    // predictor state
    logic [31:0] key_words [16];
    logic [31:0] chain [8];
    logic [31:0] blk_words [16];
    int unsigned fill;
    logic [63:0] bit_count;
    logic [63:0] key_bytes;
    mac_phase_e  mac_phase;

    byte_item_t  pending_items [$];
    mac_word_t   mac_words_due [$];
    int          error_count;
    int          words_seen;
    int          macs_seen;
    bit          burst_on;
    int          burst_left;
    int          stall_phase;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block(input logic [31:0] blk [16]);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] += v[i];
    endtask

    task automatic put_byte(inout logic [31:0] buf_w [16], input int idx,
                            input logic [7:0] b);
        buf_w[(idx >> 2) & 15][(3 - (idx & 3)) * 8 +: 8] = b;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        put_byte(blk_words, fill, b);
        fill++;
        bit_count += 64'd8;
        if (fill >= 64)
        begin
            compress_block(blk_words);
            fill = 0;
        end
    endtask

    task automatic close_hash();
        put_byte(blk_words, fill, 8'h80);
        fill++;
        if (fill > 56)
        begin
            while (fill < 64) begin put_byte(blk_words, fill, 8'h00); fill++; end
            compress_block(blk_words);
            fill = 0;
        end
        while (fill < 56) begin put_byte(blk_words, fill, 8'h00); fill++; end
        blk_words[14] = bit_count[63:32];
        blk_words[15] = bit_count[31:0];
        compress_block(blk_words);
        fill = 0;
    endtask

    task automatic open_padded_hash(input logic [7:0] pad);
        logic [31:0] blk [16];
        for (int i = 0; i < 16; i++) blk[i] = key_words[i] ^ {4{pad}};
        for (int i = 0; i < 8; i++) chain[i] = START_H[i];
        compress_block(blk);
        fill = 0;
        bit_count = 64'd512;
    endtask

    task automatic clear_mac_state();
        for (int i = 0; i < 16; i++) begin key_words[i] = '0; blk_words[i] = '0; end
        for (int i = 0; i < 8; i++) chain[i] = START_H[i];
        fill = 0;
        bit_count = '0;
        key_bytes = '0;
        mac_phase = WAIT_KEY;
    endtask

    task automatic predict_mac(input byte_item_t it);
        logic [31:0] inner [8];
        if (mac_phase != WAIT_MSG)
        begin
            if (it.func != FUNC_KEY) return;
            if (it.byte_valid)
            begin
                if (mac_phase == LONG_KEY)
                    absorb_byte(it.data_byte);
                else if (key_bytes < 64)
                    put_byte(key_words, int'(key_bytes), it.data_byte);
                else
                begin
                    for (int i = 0; i < 8; i++) chain[i] = START_H[i];
                    compress_block(key_words);
                    fill = 0;
                    bit_count = 64'd512;
                    mac_phase = LONG_KEY;
                    absorb_byte(it.data_byte);
                end
                key_bytes++;
            end
            if (it.last)
            begin
                if (mac_phase == LONG_KEY)
                begin
                    close_hash();
                    for (int i = 0; i < 8; i++) key_words[i] = chain[i];
                    for (int i = 8; i < 16; i++) key_words[i] = '0;
                end
                open_padded_hash(PAD_IN);
                mac_phase = WAIT_MSG;
            end
            return;
        end
        if (it.func != FUNC_MSG) return;
        if (it.byte_valid) absorb_byte(it.data_byte);
        if (!it.last) return;
        close_hash();
        for (int i = 0; i < 8; i++) inner[i] = chain[i];
        open_padded_hash(PAD_OUT);
        for (int i = 0; i < 32; i++) absorb_byte(inner[i >> 2][(3 - (i & 3)) * 8 +: 8]);
        close_hash();
        for (int i = 0; i < 8; i++) mac_words_due.push_back('{chain[i], i == 7});
        clear_mac_state();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("MISMATCH %s at word %0d: got %h, expected %h", what, words_seen, got, want);
    endtask

    function automatic byte_item_t mk(input logic f, input logic [7:0] b,
                                      input logic bv, input logic l);
        return '{f, b, bv, l, 1'b0};
    endfunction

    task automatic add_part(input logic f, input int len);
        for (int i = 0; i < len; i++)
            pending_items.push_back(mk(f, 8'($urandom_range(0, 255)), 1'b1, i == len - 1));
        if (len == 0) pending_items.push_back(mk(f, 8'($urandom), 1'b0, 1'b1));
    endtask

    // short parts mostly, some across the pad and block boundaries
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (pending_items.size() > 150) return $urandom_range(0, 6);
        if (r < 7) return $urandom_range(0, 12);
        return $urandom_range(55, 66);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("hmac_sha256_engine regression: fail");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= 1'b0; data_byte <= '0; byte_valid <= 1'b0; last <= 1'b0;
            burst_on <= 1'b0; burst_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready) predict_mac('{func, data_byte, byte_valid, last, 1'b0});
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && pending_items[0].hold
                    && (mac_words_due.size() > 0 || out_valid))
                    in_valid <= 1'b0;
                else if (pending_items.size() > 0 && burst_left > 0)
                begin
                    in_valid <= 1'b1;
                    func <= pending_items[0].func;
                    data_byte <= pending_items[0].data_byte;
                    byte_valid <= pending_items[0].byte_valid;
                    last <= pending_items[0].last;
                    void'(pending_items.pop_front());
                    burst_left <= burst_left - 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if ($urandom_range(0, 3) == 0) burst_left <= $urandom_range(1, 40);
                end
            end
        end
    end

    // receiver stall pattern and monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            out_ready <= (stall_phase % 64 < 24) ? 1'b1 : ($urandom_range(0, 2) != 0);
            if (out_valid && out_ready)
            begin
                if (mac_words_due.size() == 0)
                begin
                    report_mismatch("unexpected digest_word", digest_word, 32'h0);
                end
                else
                begin
                    if (digest_word !== mac_words_due[0].word)
                        report_mismatch("digest_word", digest_word, mac_words_due[0].word);
                    if (last_word !== mac_words_due[0].last_word)
                        report_mismatch("last_word", {31'h0, last_word},
                                        {31'h0, mac_words_due[0].last_word});
                    if (mac_words_due[0].last_word) macs_seen++;
                    void'(mac_words_due.pop_front());
                end
                words_seen++;
            end
        end
    end

    initial
    begin
        byte_item_t h;
        int n;
        error_count = 0; words_seen = 0; macs_seen = 0;
        clear_mac_state();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty key and message, ignored items, extremes, 64/65-byte keys
        pending_items.push_back(mk(FUNC_MSG, 8'hff, 1'b1, 1'b1));
        pending_items.push_back(mk(FUNC_KEY, 8'h00, 1'b0, 1'b0));
        pending_items.push_back(mk(FUNC_KEY, 8'h00, 1'b0, 1'b1));
        pending_items.push_back(mk(FUNC_KEY, 8'hff, 1'b1, 1'b1));
        pending_items.push_back(mk(FUNC_MSG, 8'h00, 1'b0, 1'b1));
        pending_items.push_back(mk(FUNC_KEY, 8'hff, 1'b1, 1'b0));
        pending_items.push_back(mk(FUNC_KEY, 8'h00, 1'b1, 1'b1));
        pending_items.push_back(mk(FUNC_KEY, 8'h55, 1'b1, 1'b1));
        pending_items.push_back(mk(FUNC_MSG, 8'h00, 1'b1, 1'b0));
        pending_items.push_back(mk(FUNC_MSG, 8'hff, 1'b0, 1'b0));
        pending_items.push_back(mk(FUNC_MSG, 8'haa, 1'b1, 1'b1));
        add_part(FUNC_KEY, 64); add_part(FUNC_MSG, 3);
        add_part(FUNC_KEY, 65); add_part(FUNC_MSG, 0);

        // random sessions, mostly well-formed, some stray items
        n = 0;
        while (pending_items.size() < 172)
        begin
            h = mk(FUNC_KEY, 8'($urandom), 1'b0, 1'b0);
            if ($urandom_range(0, 5) == 0)
            begin
                pending_items.push_back(mk(FUNC_MSG, 8'($urandom), 1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1))));
                pending_items.push_back(h);
            end
            add_part(FUNC_KEY, pick_len());
            if ($urandom_range(0, 5) == 0)
                pending_items.push_back(mk(FUNC_KEY, 8'($urandom), 1'b1, 1'b1));
            add_part(FUNC_MSG, pick_len());
            n = n + 1;
            if (n == 1) pending_items[pending_items.size() - 1].hold = 1'b1;
        end
        // hold-off: next session waits until all MAC words are back
        h = mk(FUNC_KEY, 8'h3c, 1'b1, 1'b1);
        h.hold = 1'b1;
        pending_items.push_back(h);
        add_part(FUNC_MSG, 3);

        wait (pending_items.size() == 0 && !in_valid);
        wait (mac_words_due.size() == 0);
        repeat (2000) @(posedge clk);
        $display("covered %0d MACs (%0d words), short, empty and long keys and messages",
                 macs_seen, words_seen);
        $display("stray wrong-part and empty items mixed in, random bursts and stalls");
        if (error_count == 0 && mac_words_due.size() == 0)
            $display("hmac_sha256_engine regression: pass");
        else
            $display("hmac_sha256_engine regression: fail");
        $finish;
    end

endmodule
